FILE: hw/rtl/klx_pkg.sv
package klx_pkg;

  typedef enum logic [3:0] {
    KIND_IDENT      = 4'd0,
    KIND_INT_LIT    = 4'd1,
    KIND_STRING     = 4'd2,
    KIND_SPACE      = 4'd3,
    KIND_EQ         = 4'd4,
    KIND_COLON      = 4'd5,
    KIND_PLUS       = 4'd6,
    KIND_LPAREN     = 4'd7,
    KIND_RPAREN     = 4'd8,
    KIND_SEMI       = 4'd9,
    KIND_UNKNOWN    = 4'd10,
    KIND_KW_INT     = 4'd11,
    KIND_KW_DISP    = 4'd12,
    KIND_KW_RET     = 4'd13,
    KIND_KW_TAGSTOP = 4'd14
  } kind_e;

  typedef enum logic [2:0] {
    LM_IDLE    = 3'd0,
    LM_WORD    = 3'd1,
    LM_NUM     = 3'd2,
    LM_STR     = 3'd3,
    LM_COMMENT = 3'd4,
    LM_DASH    = 3'd5,
    LM_STOP    = 3'd6
  } lex_mode_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] start_offset;
    logic [15:0] span_length;
    logic [7:0]  lead_char;
    logic        run_last;
    logic        text_done;
  } token_t;

  // all tokens caused by one text byte
  typedef struct packed {
    logic   two;
    token_t first;
    token_t second;
  } tok_pair_t;

  localparam int unsigned MaxWord   = 32;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoAw    = $clog2(FifoDepth);

  typedef logic [FifoAw-1:0] fifo_ptr_t;
  typedef logic [FifoAw:0]   fifo_cnt_t;

  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChSpace  = 8'h20;
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChLparen = 8'h28;
  localparam logic [7:0] ChRparen = 8'h29;
  localparam logic [7:0] ChPlus   = 8'h2B;
  localparam logic [7:0] ChDash   = 8'h2D;
  localparam logic [7:0] ChColon  = 8'h3A;
  localparam logic [7:0] ChSemi   = 8'h3B;
  localparam logic [7:0] ChEq     = 8'h3D;

  // keywords: int, disp, ret, tagstop
  localparam logic [7:0] KwText [4][8] = '{
    '{8'h69, 8'h6E, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h64, 8'h69, 8'h73, 8'h70, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h72, 8'h65, 8'h74, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{8'h74, 8'h61, 8'h67, 8'h73, 8'h74, 8'h6F, 8'h70, 8'h00}
  };
  localparam logic [15:0] KwLen [4] = '{16'd3, 16'd4, 16'd3, 16'd7};

endpackage

FILE: hw/rtl/klx_if.sv
interface klx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       final_byte;

  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink (input valid, input text_byte, input final_byte, output ready);
endinterface

interface klx_out_if;
  logic            valid;
  logic            ready;
  klx_pkg::kind_e  kind;
  logic [15:0]     start_offset;
  logic [15:0]     span_length;
  logic [7:0]      lead_char;
  logic            run_last;
  logic            text_done;

  modport source (output valid, output kind, output start_offset, output span_length,
                  output lead_char, output run_last, output text_done, input ready);
  modport sink (input valid, input kind, input start_offset, input span_length,
                input lead_char, input run_last, input text_done, output ready);
endinterface

FILE: hw/rtl/klx_front.sv
module klx_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  klx_in_if.sink             text_i,
  output logic               push_valid_o,
  input  logic               push_ready_i,
  output klx_pkg::tok_pair_t push_data_o
);
  import klx_pkg::*;

  lex_mode_e   mode_q, mode_d, mid_mode;
  logic [15:0] off_q, off_d;
  logic [15:0] start_q, start_d, mid_start;
  logic [15:0] len_q, len_d, mid_len;
  logic [3:0]  hits_q, hits_d, mid_hits;
  logic [7:0]  fc_q, fc_d, mid_fc;

  logic [7:0]  c;
  logic        fin, accept;
  logic        is_letter, is_digit, is_alnum;
  logic        word_cont, num_cont, do_idle;
  logic [3:0]  hits_upd, ib_hits;
  lex_mode_e   ib_mode;
  logic        ib_emit;
  kind_e       ib_kind;
  kind_e       a_kind;
  logic        a_v, b_v, c_v;
  token_t      a_tok, b_tok, c_tok;
  tok_pair_t   pair;

  function automatic kind_e word_kind(logic [3:0] hits, logic [15:0] len);
    kind_e k;
    k = KIND_IDENT;
    if (hits[0] && len == KwLen[0]) k = KIND_KW_INT;
    if (hits[1] && len == KwLen[1]) k = KIND_KW_DISP;
    if (hits[2] && len == KwLen[2]) k = KIND_KW_RET;
    if (hits[3] && len == KwLen[3]) k = KIND_KW_TAGSTOP;
    return k;
  endfunction

  assign c      = text_i.text_byte;
  assign fin    = text_i.final_byte;
  assign accept = text_i.valid && push_ready_i;

  assign is_letter = c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
  assign is_digit  = c inside {[8'h30:8'h39]};
  assign is_alnum  = is_letter || is_digit;
  assign word_cont = is_alnum && (len_q < 16'(MaxWord));
  assign num_cont  = is_digit && (len_q < 16'(MaxWord));
  assign a_kind    = word_kind(hits_q, len_q);

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hits_upd[i] = hits_q[i] && (len_q < KwLen[i]) && (KwText[i][len_q[2:0]] == c);
      ib_hits[i]  = (KwText[i][0] == c);
    end
  end

  // byte seen from the idle mode
  always_comb begin
    ib_mode = LM_IDLE;
    ib_emit = 1'b0;
    ib_kind = KIND_UNKNOWN;
    if (is_letter) begin
      ib_mode = LM_WORD;
    end else if (is_digit) begin
      ib_mode = LM_NUM;
    end else if (c == ChQuote) begin
      ib_mode = LM_STR;
    end else if (c == ChDash) begin
      ib_mode = LM_DASH;
    end else begin
      ib_emit = 1'b1;
      case (c)
        ChSpace, ChTab, ChLf: ib_kind = KIND_SPACE;
        ChEq:                 ib_kind = KIND_EQ;
        ChColon:              ib_kind = KIND_COLON;
        ChPlus:               ib_kind = KIND_PLUS;
        ChLparen:             ib_kind = KIND_LPAREN;
        ChRparen:             ib_kind = KIND_RPAREN;
        ChSemi:               ib_kind = KIND_SEMI;
        default:              ib_kind = KIND_UNKNOWN;
      endcase
    end
  end

  // next state
  always_comb begin
    mid_mode  = mode_q;
    mid_start = start_q;
    mid_len   = len_q;
    mid_hits  = hits_q;
    mid_fc    = fc_q;
    do_idle   = 1'b0;
    case (mode_q)
      LM_WORD: begin
        if (word_cont) begin
          mid_hits = hits_upd;
          mid_len  = len_q + 16'd1;
        end else begin
          mid_hits = 4'hF;
          if (a_kind == KIND_KW_TAGSTOP) mid_mode = LM_STOP;
          else do_idle = 1'b1;
        end
      end
      LM_NUM: begin
        if (num_cont) mid_len = len_q + 16'd1;
        else do_idle = 1'b1;
      end
      LM_STR: begin
        if (c == ChQuote) begin
          mid_mode = LM_IDLE;
        end else begin
          if (len_q == 16'd0) mid_fc = c;
          if (len_q != 16'hFFFF) mid_len = len_q + 16'd1;
        end
      end
      LM_COMMENT: begin
        if (c == ChLf) do_idle = 1'b1;
      end
      LM_DASH: begin
        if (c == ChDash) mid_mode = LM_COMMENT;
        else do_idle = 1'b1;
      end
      LM_STOP: begin
      end
      default: do_idle = 1'b1;
    endcase
    if (do_idle) begin
      mid_mode = ib_mode;
      if (!ib_emit) begin
        mid_start = (c == ChQuote) ? off_q + 16'd1 : off_q;
        mid_len   = (c == ChQuote) ? 16'd0 : 16'd1;
        mid_fc    = (c == ChQuote) ? 8'h00 : c;
      end
      if (is_letter) mid_hits = ib_hits;
    end
    mode_d  = fin ? LM_IDLE : mid_mode;
    hits_d  = fin ? 4'hF : mid_hits;
    off_d   = fin ? 16'd0 : off_q + 16'd1;
    start_d = mid_start;
    len_d   = mid_len;
    fc_d    = mid_fc;
  end

  // tokens
  always_comb begin
    a_v   = 1'b0;
    a_tok = '{kind: a_kind, start_offset: start_q, span_length: len_q, lead_char: fc_q,
              run_last: 1'b0, text_done: a_kind == KIND_KW_TAGSTOP};
    case (mode_q)
      LM_WORD: a_v = !word_cont;
      LM_NUM: begin
        a_v = !num_cont;
        a_tok.kind = KIND_INT_LIT;
        a_tok.text_done = 1'b0;
      end
      LM_STR: begin
        a_v = (c == ChQuote);
        a_tok.kind = KIND_STRING;
        a_tok.text_done = 1'b0;
      end
      LM_DASH: begin
        a_v = (c != ChDash);
        a_tok.kind = KIND_UNKNOWN;
        a_tok.span_length = 16'd1;
        a_tok.lead_char = ChDash;
        a_tok.text_done = 1'b0;
      end
      default: a_v = 1'b0;
    endcase

    b_v   = do_idle && ib_emit;
    b_tok = '{kind: ib_kind, start_offset: off_q, span_length: 16'd1, lead_char: c,
              run_last: 1'b0, text_done: 1'b0};

    c_tok = '{kind: word_kind(mid_hits, mid_len), start_offset: mid_start,
              span_length: mid_len, lead_char: mid_fc, run_last: 1'b0,
              text_done: word_kind(mid_hits, mid_len) == KIND_KW_TAGSTOP};
    c_v   = 1'b0;
    case (mid_mode)
      LM_WORD: c_v = fin;
      LM_NUM: begin
        c_v = fin;
        c_tok.kind = KIND_INT_LIT;
        c_tok.text_done = 1'b0;
      end
      LM_STR: begin
        c_v = fin;
        c_tok.kind = KIND_STRING;
        c_tok.text_done = 1'b0;
      end
      LM_DASH: begin
        c_v = fin;
        c_tok.kind = KIND_UNKNOWN;
        c_tok.span_length = 16'd1;
        c_tok.lead_char = ChDash;
        c_tok.text_done = 1'b0;
      end
      default: c_v = 1'b0;
    endcase

    // at most two of the three fire, and never the idle token with the final flush
    pair.first  = a_v ? a_tok : (b_v ? b_tok : c_tok);
    pair.second = b_v ? b_tok : c_tok;
    pair.two    = a_v && (b_v || c_v);
    if (pair.two) begin
      pair.second.run_last  = 1'b1;
      pair.second.text_done = pair.second.text_done || fin;
    end else begin
      pair.first.run_last  = 1'b1;
      pair.first.text_done = pair.first.text_done || fin;
    end
  end

  assign text_i.ready = push_ready_i;
  assign push_valid_o = text_i.valid && (a_v || b_v || c_v);
  assign push_data_o  = pair;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= LM_IDLE;
      off_q   <= 16'd0;
      hits_q  <= 4'hF;
      start_q <= 16'd0;
      len_q   <= 16'd0;
      fc_q    <= 8'h00;
    end else if (accept) begin
      mode_q  <= mode_d;
      off_q   <= off_d;
      hits_q  <= hits_d;
      start_q <= start_d;
      len_q   <= len_d;
      fc_q    <= fc_d;
    end
  end

  a_hits_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q != LM_WORD |-> hits_q == 4'hF)
    else $error("keyword hits not cleared outside a word");

  a_word_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == LM_WORD |-> len_q != 16'd0 && len_q <= 16'(MaxWord))
    else $error("word length out of range");

  a_final_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && fin |=> off_q == 16'd0 && mode_q == LM_IDLE)
    else $error("final byte did not restart the lexer");

endmodule

FILE: hw/rtl/klx_fifo.sv
module klx_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  input  klx_pkg::tok_pair_t push_data_i,
  output logic               pop_valid_o,
  input  logic               pop_ready_i,
  output klx_pkg::tok_pair_t pop_data_o
);
  import klx_pkg::*;

  tok_pair_t mem_q [FifoDepth];
  fifo_ptr_t wr_ptr_q, rd_ptr_q;
  fifo_cnt_t cnt_q;
  logic      push, pop;

  assign push_ready_o = cnt_q != fifo_cnt_t'(FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + fifo_ptr_t'(1);
      if (pop) rd_ptr_q <= rd_ptr_q + fifo_ptr_t'(1);
      if (push && !pop) cnt_q <= cnt_q + fifo_cnt_t'(1);
      else if (pop && !push) cnt_q <= cnt_q - fifo_cnt_t'(1);
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fifo_cnt_t'(FifoDepth))
    else $error("queue count overflow");

endmodule

FILE: hw/rtl/klx_back.sv
module klx_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               pop_valid_i,
  output logic               pop_ready_o,
  input  klx_pkg::tok_pair_t pop_data_i,
  klx_out_if.source          tok_o
);
  import klx_pkg::*;

  logic   out_valid_q, second_v_q;
  token_t out_tok_q, second_tok_q;
  logic   load;

  assign load        = !out_valid_q || tok_o.ready;
  assign pop_ready_o = load && !second_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      second_v_q  <= 1'b0;
    end else if (load) begin
      if (second_v_q) begin
        out_valid_q <= 1'b1;
        second_v_q  <= 1'b0;
      end else begin
        out_valid_q <= pop_valid_i;
        second_v_q  <= pop_valid_i && pop_data_i.two;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (second_v_q) begin
        out_tok_q <= second_tok_q;
      end else if (pop_valid_i) begin
        out_tok_q    <= pop_data_i.first;
        second_tok_q <= pop_data_i.second;
      end
    end
  end

  assign tok_o.valid        = out_valid_q;
  assign tok_o.kind         = out_tok_q.kind;
  assign tok_o.start_offset = out_tok_q.start_offset;
  assign tok_o.span_length  = out_tok_q.span_length;
  assign tok_o.lead_char    = out_tok_q.lead_char;
  assign tok_o.run_last     = out_tok_q.run_last;
  assign tok_o.text_done    = out_tok_q.text_done;

  a_second_behind_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_v_q |-> out_valid_q)
    else $error("second token pending without a shown first token");

endmodule

FILE: hw/rtl/keyword_lexer_stream.sv
// Each token a byte completes is written into the queue and then loaded into the output
// register, from which it is shown at the output.
// Throughput: one byte per cycle while the queue has room; a byte with two tokens shows them
// one after the other, and a four-entry queue between lexer and output register absorbs those.
// Bytes that complete no token produce no output word.
// Reset (rst_ni low, asynchronous): lexer idle, offset zero, queue and output empty.
module keyword_lexer_stream (
  input  logic      clk_i,
  input  logic      rst_ni,
  klx_in_if.sink    text_i,
  klx_out_if.source tok_o
);
  import klx_pkg::*;

  logic      push_valid, push_ready, pop_valid, pop_ready;
  tok_pair_t push_data, pop_data;

  klx_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .text_i       (text_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  klx_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  klx_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .tok_o       (tok_o)
  );

endmodule

FILE: tb/sv/klx_token_checker.sv
`timescale 1ns / 100ps

module klx_token_checker
  import klx_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  klx_in_if           text_mon,
  klx_out_if          tok_mon,
  output int unsigned mismatches_o,
  output int unsigned pending_o
);

  string kw_words [4] = '{"int", "disp", "ret", "tagstop"};
  kind_e kw_kinds [4] = '{KIND_KW_INT, KIND_KW_DISP, KIND_KW_RET, KIND_KW_TAGSTOP};

  lex_mode_e   mode_q;
  logic [15:0] start_q;
  logic [15:0] len_q;
  logic [3:0]  hits_q;
  logic [15:0] offset_q;
  logic [7:0]  lead_q;

  token_t      step_tok [2];
  int unsigned step_cnt;
  token_t      expected_tokens [$];
  token_t      want;
  int unsigned err_cnt;

  function automatic bit is_alpha(input logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
  endfunction

  function automatic bit is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  task automatic add_token(input kind_e k, input logic [15:0] s, input logic [15:0] l,
                           input logic [7:0] ch, input logic done);
    if (step_cnt < 2) begin
      step_tok[step_cnt] = '{kind: k, start_offset: s, span_length: l, lead_char: ch,
                             run_last: 1'b0, text_done: done};
      step_cnt++;
    end
  endtask

  task automatic track_keyword(input logic [7:0] c);
    for (int i = 0; i < 4; i++) begin
      if (!(len_q < kw_words[i].len() && kw_words[i][len_q[2:0]] == c)) hits_q[i] = 1'b0;
    end
  endtask

  task automatic close_word(output bit stopped);
    kind_e k;
    k = KIND_IDENT;
    for (int i = 0; i < 4; i++) begin
      if (hits_q[i] && len_q == kw_words[i].len()) k = kw_kinds[i];
    end
    add_token(k, start_q, len_q, lead_q, k == KIND_KW_TAGSTOP);
    hits_q  = 4'hF;
    stopped = (k == KIND_KW_TAGSTOP);
    mode_q  = stopped ? LM_STOP : LM_IDLE;
  endtask

  task automatic open_token(input logic [7:0] c, input logic [15:0] off);
    mode_q = LM_IDLE;
    if (is_alpha(c)) begin
      mode_q  = LM_WORD;
      start_q = off;
      len_q   = 16'd0;
      lead_q  = c;
      hits_q  = 4'hF;
      track_keyword(c);
      len_q   = 16'd1;
    end else if (is_num(c)) begin
      mode_q  = LM_NUM;
      start_q = off;
      len_q   = 16'd1;
      lead_q  = c;
    end else begin
      case (c)
        ChSpace, ChTab, ChLf: add_token(KIND_SPACE, off, 16'd1, c, 1'b0);
        ChEq:     add_token(KIND_EQ, off, 16'd1, c, 1'b0);
        ChColon:  add_token(KIND_COLON, off, 16'd1, c, 1'b0);
        ChPlus:   add_token(KIND_PLUS, off, 16'd1, c, 1'b0);
        ChLparen: add_token(KIND_LPAREN, off, 16'd1, c, 1'b0);
        ChRparen: add_token(KIND_RPAREN, off, 16'd1, c, 1'b0);
        ChSemi:   add_token(KIND_SEMI, off, 16'd1, c, 1'b0);
        ChQuote: begin
          mode_q  = LM_STR;
          start_q = off + 16'd1;
          len_q   = 16'd0;
          lead_q  = 8'd0;
        end
        ChDash: begin
          mode_q  = LM_DASH;
          start_q = off;
          len_q   = 16'd1;
          lead_q  = c;
        end
        default: add_token(KIND_UNKNOWN, off, 16'd1, c, 1'b0);
      endcase
    end
  endtask

  task automatic lex_byte(input logic [7:0] c, input logic fin);
    logic [15:0] off;
    bit          stopped;
    off      = offset_q;
    step_cnt = 0;
    case (mode_q)
      LM_WORD: begin
        if ((is_alpha(c) || is_num(c)) && len_q < MaxWord) begin
          track_keyword(c);
          len_q++;
        end else begin
          close_word(stopped);
          if (!stopped) open_token(c, off);
        end
      end
      LM_NUM: begin
        if (is_num(c) && len_q < MaxWord) begin
          len_q++;
        end else begin
          add_token(KIND_INT_LIT, start_q, len_q, lead_q, 1'b0);
          open_token(c, off);
        end
      end
      LM_STR: begin
        if (c == ChQuote) begin
          add_token(KIND_STRING, start_q, len_q, lead_q, 1'b0);
          mode_q = LM_IDLE;
        end else begin
          if (len_q == 16'd0) lead_q = c;
          if (len_q != 16'hFFFF) len_q++;
        end
      end
      LM_COMMENT: begin
        if (c == ChLf) open_token(c, off);
      end
      LM_DASH: begin
        if (c == ChDash) begin
          mode_q = LM_COMMENT;
        end else begin
          add_token(KIND_UNKNOWN, start_q, 16'd1, ChDash, 1'b0);
          open_token(c, off);
        end
      end
      LM_STOP: ;
      default: open_token(c, off);
    endcase

    // end of text flushes whatever is still open
    if (fin) begin
      case (mode_q)
        LM_WORD: close_word(stopped);
        LM_NUM:  add_token(KIND_INT_LIT, start_q, len_q, lead_q, 1'b0);
        LM_STR:  add_token(KIND_STRING, start_q, len_q, lead_q, 1'b0);
        LM_DASH: add_token(KIND_UNKNOWN, start_q, 16'd1, ChDash, 1'b0);
        default: ;
      endcase
      mode_q   = LM_IDLE;
      hits_q   = 4'hF;
      offset_q = 16'd0;
      if (step_cnt > 0) step_tok[step_cnt-1].text_done = 1'b1;
    end else begin
      offset_q = off + 16'd1;
    end
    if (step_cnt > 0) step_tok[step_cnt-1].run_last = 1'b1;
    for (int i = 0; i < step_cnt; i++) expected_tokens.push_back(step_tok[i]);
  endtask

  task automatic compare_field(input string name, input logic [15:0] exp_v,
                               input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   = LM_IDLE;
      start_q  = 16'd0;
      len_q    = 16'd0;
      hits_q   = 4'hF;
      offset_q = 16'd0;
      lead_q   = 8'd0;
      err_cnt  = 0;
      expected_tokens.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (tok_mon.valid && tok_mon.ready) begin
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected word, expected none actual kind %0d offset %0d length %0d",
                   $time, tok_mon.kind, tok_mon.start_offset, tok_mon.span_length);
          err_cnt++;
        end else begin
          want = expected_tokens.pop_front();
          compare_field("kind", want.kind, tok_mon.kind);
          compare_field("start_offset", want.start_offset, tok_mon.start_offset);
          compare_field("span_length", want.span_length, tok_mon.span_length);
          compare_field("lead_char", want.lead_char, tok_mon.lead_char);
          compare_field("run_last", want.run_last, tok_mon.run_last);
          compare_field("text_done", want.text_done, tok_mon.text_done);
        end
      end
      if (text_mon.valid && text_mon.ready) lex_byte(text_mon.text_byte, text_mon.final_byte);
      mismatches_o <= err_cnt;
      pending_o    <= expected_tokens.size();
    end
  end

endmodule

FILE: tb/sv/tb_keyword_lexer_stream.sv
`timescale 1ns / 100ps

module tb_keyword_lexer_stream;
  import klx_pkg::*;

  localparam int unsigned IDLE_PCT     = 22;
  localparam int unsigned RANDOM_ITEMS = 1800;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 20;

  logic        clk   = 1'b0;
  logic        rst_n = 1'b0;
  bit          stall_en = 1'b1;
  int unsigned sent_cnt;
  int unsigned rand_base;
  int unsigned quiet_cycles;
  int unsigned mismatches;
  int unsigned pending;
  logic [7:0]  text_q [$];

  string kw_pool [14] = '{"int", "disp", "ret", "in", "dis", "re", "tag", "tagsto",
                          "intx", "disp9", "rets", "tagstopp", "Int", "tagstop"};
  string punct = "=:+();";
  string blank = " \t\n";

  klx_in_if  text_if ();
  klx_out_if tok_if ();

  keyword_lexer_stream dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .text_i (text_if),
    .tok_o  (tok_if)
  );

  klx_token_checker token_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .text_mon     (text_if),
    .tok_mon      (tok_if),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always #4 clk = ~clk;

  initial begin
    tok_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      tok_if.ready <= !stall_en || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((text_if.valid && text_if.ready) || (tok_if.valid && tok_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("FAILED: results differ");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] rand_letter();
    int unsigned n;
    n = $urandom_range(51);
    return (n < 26) ? 8'("A" + n) : 8'("a" + n - 26);
  endfunction

  function automatic logic [7:0] rand_alnum();
    int unsigned n;
    n = $urandom_range(61);
    return (n < 10) ? 8'("0" + n) : rand_letter();
  endfunction

  function automatic logic [7:0] rand_byte_except(input logic [7:0] x);
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == x);
    return b;
  endfunction

  function automatic int unsigned rand_run_len();
    return ($urandom_range(9) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 8);
  endfunction

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic send_byte(input logic [7:0] c, input logic fin);
    while (stall_en && $urandom_range(99) < IDLE_PCT) begin
      text_if.valid <= 1'b0;
      @(posedge clk);
    end
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= c;
    text_if.final_byte <= fin;
    @(posedge clk);
    while (!text_if.ready) @(posedge clk);
    sent_cnt++;
  endtask

  task automatic send_text();
    for (int i = 0; i < text_q.size(); i++) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  task automatic build_text();
    int unsigned n_tok;
    int unsigned pick;
    int unsigned len;
    n_tok = $urandom_range(1, 30);
    for (int t = 0; t < n_tok; t++) begin
      pick = $urandom_range(99);
      if (pick < 25) begin
        if ($urandom_range(2) == 0) begin
          push_str(kw_pool[$urandom_range(12)]);
        end else begin
          len = rand_run_len();
          text_q.push_back(rand_letter());
          for (int i = 1; i < len; i++) text_q.push_back(rand_alnum());
        end
      end else if (pick < 38) begin
        len = rand_run_len();
        for (int i = 0; i < len; i++) text_q.push_back(8'("0" + $urandom_range(9)));
      end else if (pick < 48) begin
        text_q.push_back(ChQuote);
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) text_q.push_back(rand_byte_except(ChQuote));
        if ($urandom_range(9) != 0) text_q.push_back(ChQuote);
      end else if (pick < 61) begin
        text_q.push_back(punct[$urandom_range(5)]);
      end else if (pick < 70) begin
        text_q.push_back(blank[$urandom_range(2)]);
      end else if (pick < 77) begin
        push_str("--");
        len = $urandom_range(0, 8);
        for (int i = 0; i < len; i++) text_q.push_back(rand_byte_except(ChLf));
        if ($urandom_range(9) != 0) text_q.push_back(ChLf);
      end else if (pick < 82) begin
        text_q.push_back(ChDash);
      end else if (pick < 84) begin
        push_str(kw_pool[13]);
      end else begin
        text_q.push_back(8'($urandom_range(255)));
      end
      if ($urandom_range(9) < 4) text_q.push_back(blank[$urandom_range(2)]);
    end
  endtask

  initial begin
    text_if.valid      <= 1'b0;
    text_if.text_byte  <= 8'd0;
    text_if.final_byte <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    push_str("int\tdisp(ret)=x9:12+;");
    send_text();
    // strings incl. empty, lone dash, NUL/0xFF, comment, tagstop with ignored tail
    push_str("\"a\"\"\"-");
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    push_str("--c\ntagstop;x");
    send_text();

    rand_base = sent_cnt;
    while (sent_cnt - rand_base < RANDOM_ITEMS) begin
      stall_en = !((sent_cnt - rand_base) inside {[700:1100]});
      build_text();
      send_text();
    end
    stall_en = 1'b1;
    text_if.valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
